// ===== src/trs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trs_pkg
// Shared constants, nest-step reciprocals and fixed-point helpers for the
// model matrix pipeline.
// ----------------------------------------------------------------------------
package trs_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int WORD_BITS  = 24;

    localparam int TRIG_W = FRAC_BITS + 2;
    localparam int SUM_W  = FRAC_BITS + 3;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [31:0] Q30_HALF_PI = 32'd1686629713;

    localparam int LANE_LAT  = 21;
    localparam int MERGE_LAT = 4;
    localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

    localparam int SIN_STEPS = 5;
    localparam int COS_STEPS = 6;

    localparam logic [7:0] SIN_K [0:4] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [5:0] SIN_S [0:4] = '{6'd39, 6'd39, 6'd38, 6'd37, 6'd35};
    localparam logic [32:0] SIN_R [0:4] = '{
        33'((66'd1 << 39) / 110), 33'((66'd1 << 39) / 72), 33'((66'd1 << 38) / 42),
        33'((66'd1 << 37) / 20), 33'((66'd1 << 35) / 6)};

    localparam logic [7:0] COS_K [0:5] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [5:0] COS_S [0:5] = '{6'd40, 6'd39, 6'd38, 6'd37, 6'd36, 6'd33};
    localparam logic [32:0] COS_R [0:5] = '{
        33'((66'd1 << 40) / 132), 33'((66'd1 << 39) / 90), 33'((66'd1 << 38) / 56),
        33'((66'd1 << 37) / 30), 33'((66'd1 << 36) / 12), 33'((66'd1 << 33) / 2)};

    function automatic logic [FRAC_BITS:0] to_frac(input logic [31:0] q);
        logic [33:0] v;
        begin
            v = (34'(q) + (34'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
            if (v > (34'd1 << FRAC_BITS)) begin
                v = 34'd1 << FRAC_BITS;
            end
            return v[FRAC_BITS:0];
        end
    endfunction

    function automatic logic signed [TRIG_W-1:0] fmul_u(input logic signed [TRIG_W-1:0] a,
                                                       input logic signed [TRIG_W-1:0] b);
        logic signed [2*TRIG_W-1:0] p;
        begin
            p = a * b;
            p = p + (2*TRIG_W)'(64'd1 << (FRAC_BITS - 1));
            return p[FRAC_BITS+TRIG_W-1:FRAC_BITS];
        end
    endfunction

    function automatic logic signed [WORD_BITS-1:0] fmul_sat(
        input logic signed [SUM_W-1:0] a, input logic signed [WORD_BITS-1:0] b);
        logic signed [SUM_W+WORD_BITS-1:0] p;
        logic signed [SUM_W+WORD_BITS-1:0] hi;
        logic signed [SUM_W+WORD_BITS-1:0] lo;
        begin
            hi = (SUM_W+WORD_BITS)'((64'd1 << (WORD_BITS - 1)) - 64'd1);
            lo = -hi - 1;
            p = a * b;
            p = p + (SUM_W+WORD_BITS)'(64'd1 << (FRAC_BITS - 1));
            p = p >>> FRAC_BITS;
            if (p > hi) begin
                p = hi;
            end else if (p < lo) begin
                p = lo;
            end
            return p[WORD_BITS-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/trs_nest.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trs_nest
// One step of the nested series: 1 - (x2*inner)/k in Q30, three stages.
// ----------------------------------------------------------------------------
module trs_nest (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_x2,
    input  wire logic [30:0] i_inner,
    input  wire logic [7:0]  i_k,
    input  wire logic [32:0] i_recip,
    input  wire logic [5:0]  i_shift,
    output logic      [31:0] o_x2,
    output logic      [30:0] o_val
);
    logic [31:0] r_m;
    logic [31:0] r_m2;
    logic [31:0] r_q0;
    logic [31:0] r_x2a;
    logic [31:0] r_x2b;
    logic [31:0] r_x2c;
    logic [30:0] r_val;
    logic [63:0] w_prod;
    logic [65:0] w_rprod;
    logic [39:0] w_qk;
    logic [39:0] w_rem;
    logic [32:0] w_q;

    assign w_prod  = 64'(i_x2) * 64'(i_inner);
    assign w_rprod = 66'(r_m) * 66'(i_recip);
    assign w_qk    = 40'(r_q0) * 40'(i_k);
    assign w_rem   = 40'(r_m2) - w_qk;
    assign w_q     = (w_rem >= 40'(i_k)) ? 33'(r_q0) + 33'd1 : 33'(r_q0);

    always_ff @(posedge i_clk) begin
        r_m   <= w_prod[61:30];
        r_x2a <= i_x2;
        r_q0  <= 32'(w_rprod >> i_shift);
        r_m2  <= r_m;
        r_x2b <= r_x2a;
        r_x2c <= r_x2b;
        r_val <= (w_q >= 33'(trs_pkg::Q30_ONE)) ? 31'd0 : 31'(33'(trs_pkg::Q30_ONE) - w_q);
    end

    assign o_x2  = r_x2c;
    assign o_val = r_val;
endmodule
`default_nettype wire

// ===== src/trs_sincos.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trs_sincos
// One angle lane: quadrant split, series sine and cosine, rounding.
// ----------------------------------------------------------------------------
module trs_sincos (
    input  wire logic                                   i_clk,
    input  wire logic        [trs_pkg::ANGLE_BITS-1:0]  i_angle,
    output logic signed      [trs_pkg::TRIG_W-1:0]      o_sin,
    output logic signed      [trs_pkg::TRIG_W-1:0]      o_cos
);
    localparam int AB = trs_pkg::ANGLE_BITS;
    localparam int TW = trs_pkg::TRIG_W;

    logic [31:0] w_r;
    logic [63:0] w_xp;
    logic [63:0] w_x2p;
    logic [63:0] w_sp;
    logic [30:0] r_x;
    logic [31:0] r_x2;
    logic [30:0] r_xd [0:15];
    logic [1:0]  r_quad [0:19];
    logic [31:0] r_sp;
    logic [31:0] r_sd0;
    logic [31:0] r_sd1;
    logic signed [TW-1:0] r_sin;
    logic signed [TW-1:0] r_cos;
    logic signed [TW-1:0] w_sv;
    logic signed [TW-1:0] w_cv;

    logic [31:0] w_sx2 [0:trs_pkg::SIN_STEPS];
    logic [30:0] w_st  [0:trs_pkg::SIN_STEPS];
    logic [31:0] w_cx2 [0:trs_pkg::COS_STEPS];
    logic [30:0] w_ct  [0:trs_pkg::COS_STEPS];

    assign w_r   = {2'b00, i_angle[AB-3:0], (32-AB)'(0)};
    assign w_xp  = 64'(w_r) * 64'(trs_pkg::Q30_HALF_PI);
    assign w_x2p = 64'(r_x) * 64'(r_x);

    assign w_sx2[0] = r_x2;
    assign w_st[0]  = trs_pkg::Q30_ONE;
    assign w_cx2[0] = r_x2;
    assign w_ct[0]  = trs_pkg::Q30_ONE;

    for (genvar g = 0; g < trs_pkg::SIN_STEPS; g++) begin : g_sin
        trs_nest u_nest (
            .i_clk  (i_clk),
            .i_x2   (w_sx2[g]),
            .i_inner(w_st[g]),
            .i_k    (trs_pkg::SIN_K[g]),
            .i_recip(trs_pkg::SIN_R[g]),
            .i_shift(trs_pkg::SIN_S[g]),
            .o_x2   (w_sx2[g+1]),
            .o_val  (w_st[g+1])
        );
    end

    for (genvar g = 0; g < trs_pkg::COS_STEPS; g++) begin : g_cos
        trs_nest u_nest (
            .i_clk  (i_clk),
            .i_x2   (w_cx2[g]),
            .i_inner(w_ct[g]),
            .i_k    (trs_pkg::COS_K[g]),
            .i_recip(trs_pkg::COS_R[g]),
            .i_shift(trs_pkg::COS_S[g]),
            .o_x2   (w_cx2[g+1]),
            .o_val  (w_ct[g+1])
        );
    end

    assign w_sp = 64'(r_xd[15]) * 64'(w_st[trs_pkg::SIN_STEPS]);
    assign w_sv = $signed(TW'(trs_pkg::to_frac(r_sd1)));
    assign w_cv = $signed(TW'(trs_pkg::to_frac({1'b0, w_ct[trs_pkg::COS_STEPS]})));

    always_ff @(posedge i_clk) begin
        r_x      <= w_xp[60:30];
        r_x2     <= w_x2p[61:30];
        r_quad[0] <= i_angle[AB-1:AB-2];
        for (int i = 1; i < 20; i++) begin
            r_quad[i] <= r_quad[i-1];
        end
        r_xd[0] <= r_x;
        for (int i = 1; i < 16; i++) begin
            r_xd[i] <= r_xd[i-1];
        end
        r_sp  <= w_sp[61:30];
        r_sd0 <= r_sp;
        r_sd1 <= r_sd0;
        case (r_quad[19])
            2'd0: begin
                r_sin <= w_sv;
                r_cos <= w_cv;
            end
            2'd1: begin
                r_sin <= w_cv;
                r_cos <= -w_sv;
            end
            2'd2: begin
                r_sin <= -w_sv;
                r_cos <= -w_cv;
            end
            default: begin
                r_sin <= -w_cv;
                r_cos <= w_sv;
            end
        endcase
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;
endmodule
`default_nettype wire

// ===== src/trs_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trs_merge
// Combine the three lanes' sines and cosines with the scales into the matrix.
// ----------------------------------------------------------------------------
module trs_merge (
    input  wire logic                                 i_clk,
    input  wire logic signed [trs_pkg::TRIG_W-1:0]    i_sx,
    input  wire logic signed [trs_pkg::TRIG_W-1:0]    i_cx,
    input  wire logic signed [trs_pkg::TRIG_W-1:0]    i_sy,
    input  wire logic signed [trs_pkg::TRIG_W-1:0]    i_cy,
    input  wire logic signed [trs_pkg::TRIG_W-1:0]    i_sz,
    input  wire logic signed [trs_pkg::TRIG_W-1:0]    i_cz,
    input  wire logic signed [trs_pkg::WORD_BITS-1:0] i_kx,
    input  wire logic signed [trs_pkg::WORD_BITS-1:0] i_ky,
    input  wire logic signed [trs_pkg::WORD_BITS-1:0] i_kz,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e11,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e12,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e13,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e21,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e22,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e23,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e31,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e32,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e33
);
    localparam int TW = trs_pkg::TRIG_W;
    localparam int SW = trs_pkg::SUM_W;
    localparam int WB = trs_pkg::WORD_BITS;

    logic signed [TW-1:0] ra_czsy, ra_szsy, ra_czcy, ra_szcy, ra_cysx, ra_cycx;
    logic signed [TW-1:0] ra_sx, ra_cx, ra_sy, ra_sz, ra_cz;
    logic signed [TW-1:0] rb_a12, rb_b12, rb_a13, rb_b13, rb_a22, rb_b22, rb_a23, rb_b23;
    logic signed [TW-1:0] rb_czcy, rb_szcy, rb_cysx, rb_cycx, rb_sy;
    logic signed [SW-1:0] rc_11, rc_12, rc_13, rc_21, rc_22, rc_23, rc_31, rc_32, rc_33;
    logic signed [WB-1:0] r_kx [0:2];
    logic signed [WB-1:0] r_ky [0:2];
    logic signed [WB-1:0] r_kz [0:2];
    logic signed [WB-1:0] r_e11, r_e12, r_e13, r_e21, r_e22, r_e23, r_e31, r_e32, r_e33;

    always_ff @(posedge i_clk) begin
        ra_czsy <= trs_pkg::fmul_u(i_cz, i_sy);
        ra_szsy <= trs_pkg::fmul_u(i_sz, i_sy);
        ra_czcy <= trs_pkg::fmul_u(i_cz, i_cy);
        ra_szcy <= trs_pkg::fmul_u(i_sz, i_cy);
        ra_cysx <= trs_pkg::fmul_u(i_cy, i_sx);
        ra_cycx <= trs_pkg::fmul_u(i_cy, i_cx);
        ra_sx <= i_sx;
        ra_cx <= i_cx;
        ra_sy <= i_sy;
        ra_sz <= i_sz;
        ra_cz <= i_cz;

        rb_a12 <= trs_pkg::fmul_u(ra_czsy, ra_sx);
        rb_b12 <= trs_pkg::fmul_u(ra_sz, ra_cx);
        rb_a13 <= trs_pkg::fmul_u(ra_czsy, ra_cx);
        rb_b13 <= trs_pkg::fmul_u(ra_sz, ra_sx);
        rb_a22 <= trs_pkg::fmul_u(ra_szsy, ra_sx);
        rb_b22 <= trs_pkg::fmul_u(ra_cz, ra_cx);
        rb_a23 <= trs_pkg::fmul_u(ra_szsy, ra_cx);
        rb_b23 <= trs_pkg::fmul_u(ra_cz, ra_sx);
        rb_czcy <= ra_czcy;
        rb_szcy <= ra_szcy;
        rb_cysx <= ra_cysx;
        rb_cycx <= ra_cycx;
        rb_sy   <= ra_sy;

        rc_11 <= SW'(rb_czcy);
        rc_12 <= SW'(rb_a12) - SW'(rb_b12);
        rc_13 <= SW'(rb_a13) + SW'(rb_b13);
        rc_21 <= SW'(rb_szcy);
        rc_22 <= SW'(rb_a22) + SW'(rb_b22);
        rc_23 <= SW'(rb_a23) - SW'(rb_b23);
        rc_31 <= -SW'(rb_sy);
        rc_32 <= SW'(rb_cysx);
        rc_33 <= SW'(rb_cycx);

        r_kx[0] <= i_kx;
        r_ky[0] <= i_ky;
        r_kz[0] <= i_kz;
        for (int i = 1; i < 3; i++) begin
            r_kx[i] <= r_kx[i-1];
            r_ky[i] <= r_ky[i-1];
            r_kz[i] <= r_kz[i-1];
        end

        r_e11 <= trs_pkg::fmul_sat(rc_11, r_kx[2]);
        r_e12 <= trs_pkg::fmul_sat(rc_12, r_ky[2]);
        r_e13 <= trs_pkg::fmul_sat(rc_13, r_kz[2]);
        r_e21 <= trs_pkg::fmul_sat(rc_21, r_kx[2]);
        r_e22 <= trs_pkg::fmul_sat(rc_22, r_ky[2]);
        r_e23 <= trs_pkg::fmul_sat(rc_23, r_kz[2]);
        r_e31 <= trs_pkg::fmul_sat(rc_31, r_kx[2]);
        r_e32 <= trs_pkg::fmul_sat(rc_32, r_ky[2]);
        r_e33 <= trs_pkg::fmul_sat(rc_33, r_kz[2]);
    end

    assign o_e11 = r_e11;
    assign o_e12 = r_e12;
    assign o_e13 = r_e13;
    assign o_e21 = r_e21;
    assign o_e22 = r_e22;
    assign o_e23 = r_e23;
    assign o_e31 = r_e31;
    assign o_e32 = r_e32;
    assign o_e33 = r_e33;
endmodule
`default_nettype wire

// ===== src/trs_model_matrix_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trs_model_matrix_unit
// Model matrix T*Rz*Ry*Rx*S from position, Euler angles and scale.
// ----------------------------------------------------------------------------
// Path: from start through the three angle lanes, then the merge stages, to o_valid.
// Throughput: one item per cycle; busy stays low, set by the fully pipelined
// series steps of each lane.
// Reset: synchronous, active low; clears the valid pipeline only.
// The receiver cannot stall; each result is shown for one cycle.
module trs_model_matrix_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [trs_pkg::WORD_BITS-1:0] i_pos_x,
    input  wire logic signed [trs_pkg::WORD_BITS-1:0] i_pos_y,
    input  wire logic signed [trs_pkg::WORD_BITS-1:0] i_pos_z,
    input  wire logic [trs_pkg::ANGLE_BITS-1:0]       i_angle_x,
    input  wire logic [trs_pkg::ANGLE_BITS-1:0]       i_angle_y,
    input  wire logic [trs_pkg::ANGLE_BITS-1:0]       i_angle_z,
    input  wire logic signed [trs_pkg::WORD_BITS-1:0] i_scale_x,
    input  wire logic signed [trs_pkg::WORD_BITS-1:0] i_scale_y,
    input  wire logic signed [trs_pkg::WORD_BITS-1:0] i_scale_z,
    output logic                                      o_valid,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e11,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e12,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e13,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e14,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e21,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e22,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e23,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e24,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e31,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e32,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e33,
    output logic signed [trs_pkg::WORD_BITS-1:0]      o_e34
);
    localparam int WB = trs_pkg::WORD_BITS;
    localparam int TW = trs_pkg::TRIG_W;
    localparam int LL = trs_pkg::LANE_LAT;
    localparam int TL = trs_pkg::TOTAL_LAT;

    logic [TL-1:0]        r_vld;
    logic signed [WB-1:0] r_kx [0:LL-1];
    logic signed [WB-1:0] r_ky [0:LL-1];
    logic signed [WB-1:0] r_kz [0:LL-1];
    logic signed [WB-1:0] r_px [0:TL-1];
    logic signed [WB-1:0] r_py [0:TL-1];
    logic signed [WB-1:0] r_pz [0:TL-1];
    logic signed [TW-1:0] w_sx, w_cx, w_sy, w_cy, w_sz, w_cz;

    assign busy = 1'b0;

    trs_sincos u_lane_x (.i_clk(i_clk), .i_angle(i_angle_x), .o_sin(w_sx), .o_cos(w_cx));
    trs_sincos u_lane_y (.i_clk(i_clk), .i_angle(i_angle_y), .o_sin(w_sy), .o_cos(w_cy));
    trs_sincos u_lane_z (.i_clk(i_clk), .i_angle(i_angle_z), .o_sin(w_sz), .o_cos(w_cz));

    trs_merge u_merge (
        .i_clk(i_clk),
        .i_sx(w_sx), .i_cx(w_cx), .i_sy(w_sy), .i_cy(w_cy), .i_sz(w_sz), .i_cz(w_cz),
        .i_kx(r_kx[LL-1]), .i_ky(r_ky[LL-1]), .i_kz(r_kz[LL-1]),
        .o_e11(o_e11), .o_e12(o_e12), .o_e13(o_e13),
        .o_e21(o_e21), .o_e22(o_e22), .o_e23(o_e23),
        .o_e31(o_e31), .o_e32(o_e32), .o_e33(o_e33)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TL-2:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_kx[0] <= i_scale_x;
        r_ky[0] <= i_scale_y;
        r_kz[0] <= i_scale_z;
        for (int i = 1; i < LL; i++) begin
            r_kx[i] <= r_kx[i-1];
            r_ky[i] <= r_ky[i-1];
            r_kz[i] <= r_kz[i-1];
        end
        r_px[0] <= i_pos_x;
        r_py[0] <= i_pos_y;
        r_pz[0] <= i_pos_z;
        for (int i = 1; i < TL; i++) begin
            r_px[i] <= r_px[i-1];
            r_py[i] <= r_py[i-1];
            r_pz[i] <= r_pz[i-1];
        end
    end

    assign o_valid = r_vld[TL-1];
    assign o_e14   = r_px[TL-1];
    assign o_e24   = r_py[TL-1];
    assign o_e34   = r_pz[TL-1];

`ifndef ASSERT_OFF
    a_valid_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, trs_pkg::TOTAL_LAT))
        else $error("result without a started item");
    a_pos_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_e14 == $past(i_pos_x, trs_pkg::TOTAL_LAT)))
        else $error("translation misaligned with item");
    a_zero_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_scale_x == '0, trs_pkg::TOTAL_LAT)) |-> (o_e31 == '0))
        else $error("zero scale gives nonzero column");
`endif
endmodule
`default_nettype wire
